// ===== src/atc_pkg.sv =====
`default_nettype none

package atc_pkg;

   // counter and result widths
   localparam int COUNT_BITS         = 16;
   localparam int MAX_PRESCALER_STEP = 5;
   localparam int RPM_BITS           = 30;
   localparam int DIV_STEPS          = RPM_BITS;
   localparam int DIV_CNT_BITS       = $clog2(DIV_STEPS + 1);

   // ticks per minute at the undivided counter clock
   localparam logic [RPM_BITS-1:0] RPM_NUMERATOR = 30'd960000000;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // event codes
   typedef enum logic [1:0] {
      CMD_START    = 2'd0,
      CMD_STOP     = 2'd1,
      CMD_OVERFLOW = 2'd2,
      CMD_CAPTURE  = 2'd3
   } command_type;

   // operating modes
   typedef enum logic [1:0] {
      MODE_STOPPED     = 2'd0,
      MODE_RUNNING     = 2'd1,
      MODE_CALIBRATING = 2'd2,
      MODE_SYNC        = 2'd3
   } mode_type;

   typedef struct packed {
      command_type           command;
      logic [COUNT_BITS-1:0] capture_count;
   } req_type;

   typedef struct packed {
      mode_type              mode;
      logic [2:0]            prescaler_step;
      logic [2:0]            counter_select;
      logic                  clear_counter;
      logic [COUNT_BITS-1:0] period;
      logic                  calibration_error;
      logic [RPM_BITS-1:0]   rpm;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic update;
      logic div_load;
      logic div_step;
      logic out_load;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
      logic out_busy;
   } dp_status_type;

   // the dividers are powers of two, so the numerator is pre-shifted
   function automatic logic [RPM_BITS-1:0] rpm_numerator(input logic [2:0] step);
      logic [RPM_BITS-1:0] num;
      begin
         case (step)
            3'd1:    num = RPM_NUMERATOR;
            3'd2:    num = RPM_NUMERATOR >> 3;
            3'd3:    num = RPM_NUMERATOR >> 6;
            3'd4:    num = RPM_NUMERATOR >> 8;
            3'd5:    num = RPM_NUMERATOR >> 10;
            default: num = '0;
         endcase
         return num;
      end
   endfunction

   // prescaler steps that carry a divider
   function automatic logic has_divider(input logic [2:0] step);
      return (step >= 3'd1) && (step <= 3'd5);
   endfunction

endpackage

`default_nettype wire

// ===== src/atc_ctrl.sv =====
`default_nettype none

module atc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire atc_pkg::dp_status_type status,
   output atc_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOAD   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // transaction acceptance only while idle
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.update   = 1'b0;
      cmd.div_load = 1'b0;
      cmd.div_step = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.update = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/atc_dpath.sv =====
`default_nettype none

module atc_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_write_data,
   input  wire atc_pkg::req_type      req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output atc_pkg::rsp_type           rsp_data,
   input  wire atc_pkg::ctrl_cmd_type cmd,
   output atc_pkg::dp_status_type     status
);

   localparam int CB = atc_pkg::COUNT_BITS;
   localparam int RB = atc_pkg::RPM_BITS;
   localparam int NB = atc_pkg::DIV_CNT_BITS;

   logic                auto_recal_ff;
   atc_pkg::mode_type   mode_ff,      mode_in;
   logic [2:0]          prescaler_ff, prescaler_in;
   logic [2:0]          clk_sel_ff,   clk_sel_in;
   logic [CB-1:0]       last_count_ff, last_count_in;
   logic [CB-1:0]       period_ff,    period_in;
   logic                overrun_ff,   overrun_in;
   logic                error_ff,     error_in;
   logic                clear_ff,     clear_in;

   logic [CB-1:0]       rem_ff,  rem_in;
   logic [RB-1:0]       quo_ff,  quo_in;
   logic [NB-1:0]       div_cnt_ff, div_cnt_in;
   logic [CB:0]         rem_shift;
   logic [CB:0]         rem_diff;
   logic                rem_ge;

   logic                rsp_valid_ff, rsp_valid_in;
   atc_pkg::rsp_type    rsp_data_ff,  rsp_data_in;

   logic [3:0]          next_step;
   logic [CB-1:0]       count;

   assign count     = req_data.capture_count;
   assign next_step = {1'b0, prescaler_ff} + 4'd1;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_recal_ff <= 1'b0;
      end else if (csr_write_enable) begin
         auto_recal_ff <= csr_write_data;
      end
   end

   // event handling
   always_comb begin
      mode_in       = mode_ff;
      prescaler_in  = prescaler_ff;
      clk_sel_in    = clk_sel_ff;
      last_count_in = last_count_ff;
      period_in     = period_ff;
      overrun_in    = overrun_ff;
      error_in      = error_ff;
      clear_in      = clear_ff;
      if (cmd.update) begin
         clear_in = 1'b0;
         case (req_data.command)
            atc_pkg::CMD_START: begin
               mode_in      = atc_pkg::MODE_SYNC;
               error_in     = 1'b0;
               overrun_in   = 1'b0;
               clear_in     = 1'b1;
               prescaler_in = 3'd1;
               if (3'd1 <= 3'(atc_pkg::MAX_PRESCALER_STEP)) begin
                  clk_sel_in = 3'd1;
               end
            end
            atc_pkg::CMD_STOP: begin
               prescaler_in = 3'd0;
               mode_in      = atc_pkg::MODE_STOPPED;
               clk_sel_in   = 3'd0;
            end
            atc_pkg::CMD_OVERFLOW: begin
               case (mode_ff)
                  atc_pkg::MODE_RUNNING: begin
                     overrun_in = 1'b1;
                  end
                  atc_pkg::MODE_CALIBRATING: begin
                     // search moves to the next divider, wrapping or stopping past the last one
                     clk_sel_in = 3'd0;
                     mode_in    = atc_pkg::MODE_SYNC;
                     if (next_step > 4'(atc_pkg::MAX_PRESCALER_STEP)) begin
                        error_in = 1'b1;
                        if (auto_recal_ff) begin
                           prescaler_in = 3'd1;
                        end else begin
                           prescaler_in = next_step[2:0];
                           mode_in      = atc_pkg::MODE_STOPPED;
                        end
                     end else begin
                        prescaler_in = next_step[2:0];
                     end
                  end
                  atc_pkg::MODE_STOPPED: begin
                     clk_sel_in = 3'd0;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
               case (mode_ff)
                  atc_pkg::MODE_RUNNING: begin
                     if (overrun_ff) begin
                        // one overflow between edges
                        if (last_count_ff < count) begin
                           if (auto_recal_ff) begin
                              mode_in = atc_pkg::MODE_CALIBRATING;
                           end else begin
                              mode_in    = atc_pkg::MODE_STOPPED;
                              clk_sel_in = 3'd0;
                           end
                        end else begin
                           period_in = atc_pkg::COUNT_MAX - last_count_ff + count;
                        end
                        overrun_in = 1'b0;
                     end else begin
                        period_in = count - last_count_ff;
                     end
                     last_count_in = count;
                  end
                  atc_pkg::MODE_SYNC: begin
                     mode_in  = atc_pkg::MODE_CALIBRATING;
                     clear_in = 1'b1;
                     if (prescaler_ff <= 3'(atc_pkg::MAX_PRESCALER_STEP)) begin
                        clk_sel_in = prescaler_ff;
                     end
                  end
                  atc_pkg::MODE_CALIBRATING: begin
                     last_count_in = count;
                     period_in     = count;
                     overrun_in    = 1'b0;
                     error_in      = 1'b0;
                     mode_in       = atc_pkg::MODE_RUNNING;
                  end
                  default: begin
                     clk_sel_in = 3'd0;
                  end
               endcase
            end
         endcase
      end
   end

   // tachometer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= atc_pkg::MODE_STOPPED;
         prescaler_ff  <= 3'd0;
         clk_sel_ff    <= 3'd0;
         last_count_ff <= atc_pkg::COUNT_MAX;
         period_ff     <= '0;
         overrun_ff    <= 1'b0;
         error_ff      <= 1'b0;
         clear_ff      <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         prescaler_ff  <= prescaler_in;
         clk_sel_ff    <= clk_sel_in;
         last_count_ff <= last_count_in;
         period_ff     <= period_in;
         overrun_ff    <= overrun_in;
         error_ff      <= error_in;
         clear_ff      <= clear_in;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, quo_ff[RB-1]};
   assign rem_diff  = rem_shift - {1'b0, period_ff};
   assign rem_ge    = (rem_shift >= {1'b0, period_ff});

   always_comb begin
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_load) begin
         rem_in     = '0;
         quo_in     = atc_pkg::rpm_numerator(prescaler_ff);
         div_cnt_in = NB'(atc_pkg::DIV_STEPS);
      end else if (cmd.div_step) begin
         rem_in     = rem_ge ? rem_diff[CB-1:0] : rem_shift[CB-1:0];
         quo_in     = {quo_ff[RB-2:0], rem_ge};
         div_cnt_in = div_cnt_ff - NB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else begin
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.div_last = (div_cnt_ff == NB'(1));
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // result register
   always_comb begin
      rsp_data_in                   = rsp_data_ff;
      rsp_data_in.mode              = mode_ff;
      rsp_data_in.prescaler_step    = prescaler_ff;
      rsp_data_in.counter_select    = clk_sel_ff;
      rsp_data_in.clear_counter     = clear_ff;
      rsp_data_in.period            = period_ff;
      rsp_data_in.calibration_error = error_ff;
      rsp_data_in.rpm               = (atc_pkg::has_divider(prescaler_ff) &&
                                       (period_ff != '0)) ? quo_ff : '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.out_load && rsp_valid_ff && rsp_stall))
      else $error("result loaded over a pending transaction");

   // divider runs its full length after a load
   a_div_load: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> (div_cnt_ff == NB'(atc_pkg::DIV_STEPS)))
      else $error("divider count not loaded");

   // start always enters synchronizing with a counter clear
   a_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && (req_data.command == atc_pkg::CMD_START)) |=>
      ((mode_ff == atc_pkg::MODE_SYNC) && clear_ff && (prescaler_ff == 3'd1)))
      else $error("start did not resynchronize");

endmodule

`default_nettype wire

// ===== src/autoranging_tachometer_capture_top.sv =====
// a transaction passes the LOAD, DIVIDE and EMIT states; EMIT waits while the output is stalled
// one transaction at a time, its rpm computed by the 30-step serial rpm divider
// the input is taken again once the result sits in the output register
// reset: synchronous, active high; clears mode, prescaler, clock select and flags,
// sets the last capture to all ones and auto_recalibrate to 0
`default_nettype none

module autoranging_tachometer_capture_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire atc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output atc_pkg::rsp_type      rsp_data
);

   atc_pkg::ctrl_cmd_type  cmd;
   atc_pkg::dp_status_type status;

   // sequencing
   atc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // event state, divider and result register
   atc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

`default_nettype wire

// ===== test/autoranging_tachometer_capture_top_test.sv =====
`timescale 1ns / 100ps

module autoranging_tachometer_capture_top_test;
   import atc_pkg::*;

   localparam int CYCLE_LIMIT        = 200000;
   localparam int LONG_HOLD          = 300;
   localparam int DRAIN_CYCLES       = 64;
   localparam int MAX_PRINTED_ERRORS = 100;
   localparam longint unsigned TICKS_PER_MINUTE = 64'd960000000;

   logic    clock            = 1'b0;
   logic    reset            = 1'b1;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data   = 1'b0;
   logic    req_valid        = 1'b0;
   logic    req_stall;
   req_type req_data         = '0;
   logic    rsp_valid;
   logic    rsp_stall        = 1'b0;
   rsp_type rsp_data;

   autoranging_tachometer_capture_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   always #1 clock = ~clock;

   // tachometer state as the block should hold it
   mode_type              tach_mode;
   logic [2:0]            tach_prescaler;
   logic [2:0]            tach_select;
   logic [COUNT_BITS-1:0] tach_last_count;
   logic [COUNT_BITS-1:0] tach_period;
   logic                  tach_overrun;
   logic                  tach_error;
   logic                  tach_recalibrate;

   rsp_type pending_reports[$];

   int cycle_count        = 0;
   int error_count        = 0;
   int reports_checked    = 0;
   int reports_with_rpm   = 0;
   int search_exhaustions = 0;
   int events_total       = 0;
   int events_by_kind[4]  = '{0, 0, 0, 0};

   bit sender_idling   = 1'b1;
   bit receiver_idling = 1'b1;
   int stall_left      = 0;
   bit hold_request    = 1'b0;
   bit hold_seen       = 1'b0;
   int hold_left       = 0;

   // ------------------------------------------------------------------
   // tachometer behavior
   // ------------------------------------------------------------------

   function automatic void tach_reset();
      tach_mode        = MODE_STOPPED;
      tach_prescaler   = 3'd0;
      tach_select      = 3'd0;
      tach_last_count  = COUNT_MAX;
      tach_period      = '0;
      tach_overrun     = 1'b0;
      tach_error       = 1'b0;
      tach_recalibrate = 1'b0;
   endfunction

   // selects beyond the largest divider are not applied
   function automatic void tach_drive_clock(input logic [2:0] sel);
      if (sel <= MAX_PRESCALER_STEP)
         tach_select = sel;
   endfunction

   // move the divider search on, wrapping or stopping past the last divider
   function automatic void tach_next_divider();
      logic [3:0] next;
      next = {1'b0, tach_prescaler} + 4'd1;
      if (next > MAX_PRESCALER_STEP) begin
         search_exhaustions++;
         tach_error = 1'b1;
         if (tach_recalibrate) begin
            tach_prescaler = 3'd1;
         end else begin
            tach_prescaler = next[2:0];
            tach_mode      = MODE_STOPPED;
            tach_drive_clock(3'd0);
         end
      end else begin
         tach_prescaler = next[2:0];
      end
   endfunction

   function automatic logic [RPM_BITS-1:0] tach_rpm();
      longint unsigned divider;
      case (tach_prescaler)
         3'd1:    divider = 1;
         3'd2:    divider = 8;
         3'd3:    divider = 64;
         3'd4:    divider = 256;
         3'd5:    divider = 1024;
         default: divider = 0;
      endcase
      if (divider == 0 || tach_period == 0)
         return '0;
      return RPM_BITS'(TICKS_PER_MINUTE / (divider * tach_period));
   endfunction

   // apply one event and build the report the block should give for it
   function automatic rsp_type tach_update(input command_type cmd,
                                           input logic [COUNT_BITS-1:0] capture);
      rsp_type report;
      logic    clear;
      clear = 1'b0;
      case (cmd)
         CMD_START: begin
            tach_mode      = MODE_SYNC;
            tach_error     = 1'b0;
            tach_overrun   = 1'b0;
            clear          = 1'b1;
            tach_prescaler = 3'd1;
            tach_drive_clock(tach_prescaler);
         end
         CMD_STOP: begin
            tach_prescaler = 3'd0;
            tach_mode      = MODE_STOPPED;
            tach_drive_clock(3'd0);
         end
         CMD_OVERFLOW: begin
            case (tach_mode)
               MODE_RUNNING: tach_overrun = 1'b1;
               MODE_CALIBRATING: begin
                  tach_drive_clock(3'd0);
                  tach_mode = MODE_SYNC;
                  tach_next_divider();
               end
               MODE_STOPPED: tach_drive_clock(3'd0);
               default: ;
            endcase
         end
         default: begin
            case (tach_mode)
               MODE_RUNNING: begin
                  if (tach_overrun) begin
                     // an interval longer than one wrap cannot be measured
                     if (tach_last_count < capture) begin
                        if (tach_recalibrate) begin
                           tach_mode = MODE_CALIBRATING;
                        end else begin
                           tach_mode = MODE_STOPPED;
                           tach_drive_clock(3'd0);
                        end
                     end else begin
                        tach_period = COUNT_MAX - tach_last_count + capture;
                     end
                     tach_overrun = 1'b0;
                  end else begin
                     tach_period = capture - tach_last_count;
                  end
                  tach_last_count = capture;
               end
               MODE_SYNC: begin
                  tach_mode = MODE_CALIBRATING;
                  clear     = 1'b1;
                  tach_drive_clock(tach_prescaler);
               end
               MODE_CALIBRATING: begin
                  tach_last_count = capture;
                  tach_period     = capture;
                  tach_overrun    = 1'b0;
                  tach_error      = 1'b0;
                  tach_mode       = MODE_RUNNING;
               end
               default: tach_drive_clock(3'd0);
            endcase
         end
      endcase
      report.mode              = tach_mode;
      report.prescaler_step    = tach_prescaler;
      report.counter_select    = tach_select;
      report.clear_counter     = clear;
      report.period            = tach_period;
      report.calibration_error = tach_error;
      report.rpm               = tach_rpm();
      return report;
   endfunction

   // ------------------------------------------------------------------
   // run limit
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, pending_reports.size());
         $display("autoranging_tachometer_capture_top regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED_ERRORS)
         $display("cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_error($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   task automatic check_report(input rsp_type got);
      rsp_type want;
      if (pending_reports.size() == 0) begin
         report_error($sformatf("report with nothing expected: %p", got));
         return;
      end
      want = pending_reports.pop_front();
      reports_checked++;
      if (want.rpm != 0)
         reports_with_rpm++;
      compare_field("mode", got.mode, want.mode);
      compare_field("prescaler_step", got.prescaler_step, want.prescaler_step);
      compare_field("counter_select", got.counter_select, want.counter_select);
      compare_field("clear_counter", got.clear_counter, want.clear_counter);
      compare_field("period", got.period, want.period);
      compare_field("calibration_error", got.calibration_error, want.calibration_error);
      compare_field("rpm", got.rpm, want.rpm);
   endtask

   // check each transaction on the result channel
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_report(rsp_data);
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= LONG_HOLD;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver stalls in random bursts
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (receiver_idling && $urandom_range(5, 0) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(6, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offer one event and record its expected report once it is taken
   task automatic send_event(input command_type cmd, input logic [COUNT_BITS-1:0] capture);
      if (sender_idling && $urandom_range(3, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(posedge clock);
      end
      req_valid              <= 1'b1;
      req_data.command       <= cmd;
      req_data.capture_count <= capture;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_reports.push_back(tach_update(cmd, capture));
      events_total++;
      events_by_kind[cmd]++;
   endtask

   task automatic wait_for_reports();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_reports.size() != 0);
   endtask

   // the register is only written while the block is idle
   task automatic write_recalibrate(input logic value);
      wait_for_reports();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tach_recalibrate = value;
   endtask

   // one divider search from a fresh start, ending on the overflow
   // that runs past the largest divider
   task automatic walk_all_dividers();
      send_event(CMD_START, 16'hFFFF);
      send_event(CMD_CAPTURE, 16'h0000);
      repeat (MAX_PRESCALER_STEP - 1) begin
         send_event(CMD_OVERFLOW, 16'h0000);
         send_event(CMD_CAPTURE, 16'hFFFF);
      end
      send_event(CMD_OVERFLOW, 16'hFFFF);
   endtask

   function automatic logic [COUNT_BITS-1:0] pick_interval();
      case ($urandom_range(3, 0))
         0:       return COUNT_BITS'($urandom_range(15, 0));
         1:       return COUNT_BITS'($urandom_range(4095, 16));
         default: return COUNT_BITS'($urandom);
      endcase
   endfunction

   // start, search a few dividers, then measure a run of edges
   task automatic measure_sequence();
      int                    steps;
      int                    edges;
      logic [COUNT_BITS-1:0] capture;
      send_event(CMD_START, COUNT_BITS'($urandom));
      send_event(CMD_CAPTURE, COUNT_BITS'($urandom));
      steps = ($urandom_range(1, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(6, 0);
      repeat (steps) begin
         send_event(CMD_OVERFLOW, COUNT_BITS'($urandom));
         send_event(CMD_CAPTURE, COUNT_BITS'($urandom));
      end
      edges = $urandom_range(8, 1);
      repeat (edges) begin
         if ($urandom_range(3, 0) == 0) begin
            send_event(CMD_OVERFLOW, COUNT_BITS'($urandom));
            if ($urandom_range(3, 0) == 0)
               capture = COUNT_BITS'($urandom);
            else
               capture = COUNT_BITS'($urandom_range(tach_last_count, 0));
         end else begin
            capture = tach_last_count + pick_interval();
         end
         send_event(CMD_CAPTURE, capture);
      end
      if ($urandom_range(1, 0) == 0)
         send_event(CMD_STOP, COUNT_BITS'($urandom));
   endtask

   task automatic random_traffic(input int count);
      int first;
      first = events_total;
      while (events_total - first < count) begin
         if ($urandom_range(7, 0) == 0) begin
            repeat ($urandom_range(3, 1))
               send_event(command_type'($urandom_range(3, 0)), COUNT_BITS'($urandom));
         end else begin
            measure_sequence();
         end
      end
      wait_for_reports();
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // overflow and capture while stopped, then a search that runs out and stops
   task automatic test_search_stops();
      write_recalibrate(1'b0);
      send_event(CMD_OVERFLOW, 16'hFFFF);
      send_event(CMD_CAPTURE, 16'h0000);
      walk_all_dividers();
      wait_for_reports();
   endtask

   // search wraps, full-scale rpm, then a too-long interval recalibrates
   task automatic test_search_wraps();
      write_recalibrate(1'b1);
      walk_all_dividers();
      send_event(CMD_CAPTURE, 16'h1234);
      send_event(CMD_CAPTURE, 16'h0000);
      send_event(CMD_CAPTURE, 16'h0001);
      send_event(CMD_OVERFLOW, 16'h0000);
      send_event(CMD_CAPTURE, 16'hFFFF);
      send_event(CMD_OVERFLOW, 16'h5555);
      send_event(CMD_STOP, 16'hAAAA);
      wait_for_reports();
   endtask

   task automatic test_random_no_recalibrate();
      write_recalibrate(1'b0);
      random_traffic(170);
   endtask

   task automatic test_random_recalibrate();
      write_recalibrate(1'b1);
      random_traffic(170);
   endtask

   // receiver holds off long enough for the block to back up
   task automatic test_backpressure();
      hold_request <= ~hold_request;
      send_event(CMD_START, 16'h0000);
      send_event(CMD_CAPTURE, 16'h0000);
      send_event(CMD_CAPTURE, 16'h0100);
      repeat (5)
         send_event(CMD_CAPTURE, tach_last_count + pick_interval());
      send_event(CMD_STOP, 16'h0000);
      wait_for_reports();
   endtask

   // steady traffic with no idling on either side
   task automatic test_back_to_back();
      sender_idling = 1'b0;
      receiver_idling <= 1'b0;
      write_recalibrate(1'b0);
      random_traffic(80);
      write_recalibrate(1'b1);
      random_traffic(80);
   endtask

   initial begin
      tach_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_search_stops();
      test_search_wraps();
      test_random_no_recalibrate();
      test_backpressure();
      test_random_recalibrate();
      test_back_to_back();

      wait_for_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d events sent (start %0d, stop %0d, overflow %0d, capture %0d)",
               events_total, events_by_kind[CMD_START], events_by_kind[CMD_STOP],
               events_by_kind[CMD_OVERFLOW], events_by_kind[CMD_CAPTURE]);
      $display("%0d reports checked, %0d with nonzero rpm, divider search ran out %0d times",
               reports_checked, reports_with_rpm, search_exhaustions);
      if (error_count == 0)
         $display("autoranging_tachometer_capture_top regression: pass");
      else
         $display("autoranging_tachometer_capture_top regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/atc_pkg.sv
src/atc_ctrl.sv
src/atc_dpath.sv
src/autoranging_tachometer_capture_top.sv
test/autoranging_tachometer_capture_top_test.sv
